// ===== src/gcd_pkg.sv =====
package gcd_pkg;

  // input and output formats
  localparam int ANGLE_FRAC_BITS = 23;
  localparam int LAT_W           = 31;
  localparam int LON_W           = 32;
  localparam int RAD_W           = 24;
  localparam int DIST_W          = 26;

  // cordic datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam int PW           = 2 * CW;
  localparam int Q_BITS       = 30;

  localparam longint ONE_Q  = longint'(1) << Q_BITS;
  localparam longint HALF_Q = longint'(1) << (Q_BITS - 1);

  localparam logic [31:0]          PI_Q30   = 32'd3373259426;
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

  localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    CW'(32'h3243F6A8), CW'(32'h1DAC6705), CW'(32'h0FADBAFC), CW'(32'h07F56EA6),
    CW'(32'h03FEAB76), CW'(32'h01FFD55B), CW'(32'h00FFFAAA), CW'(32'h007FFF55),
    CW'(32'h003FFFEA), CW'(32'h001FFFFD), CW'(32'h00100000), CW'(32'h00080000),
    CW'(32'h00040000), CW'(32'h00020000), CW'(32'h00010000), CW'(32'h00008000),
    CW'(32'h00004000), CW'(32'h00002000), CW'(32'h00001000), CW'(32'h00000800),
    CW'(32'h00000400), CW'(32'h00000200), CW'(32'h00000100), CW'(32'h00000080),
    CW'(32'h00000040), CW'(32'h00000020), CW'(32'h00000010), CW'(32'h00000008),
    CW'(32'h00000004), CW'(32'h00000002)
  };

  // angle ranges in degrees scaled by 2^ANGLE_FRAC_BITS
  localparam longint FULL_L    = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint HALF_L    = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint QUARTER_L = longint'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [34:0] FULL_DEG    = 35'(FULL_L);
  localparam logic signed [34:0] HALF_DEG    = 35'(HALF_L);
  localparam logic signed [34:0] QUARTER_DEG = 35'(QUARTER_L);

  // degrees to radians: 360 * 2^F = 45 * 2^(F+3), 180 * 2^F = 45 * 2^(F+2)
  localparam int DIV_K       = 45;
  localparam int SH_HALF     = ANGLE_FRAC_BITS + 3;
  localparam int SH_LAT      = ANGLE_FRAC_BITS + 2;
  localparam int DIV_NUM_W   = 40;
  localparam int DIV_CHUNK   = 8;
  localparam int DIV_STAGES  = DIV_NUM_W / DIV_CHUNK;

  localparam int SQ_W    = 31;
  localparam int SQ_REM  = 33;
  localparam int SQ_STEP = 31;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(6371000);
  localparam logic [DIST_W-1:0] DIST_MAX     = '1;

  // reduce an angle to [-180, 180) degrees
  function automatic logic signed [31:0] wrap_deg(input logic signed [34:0] d);
    logic signed [34:0] t;
    logic signed [34:0] r;
    t = d + HALF_DEG;
    if (t < 0) begin
      r = d + FULL_DEG;
    end else if (t >= FULL_DEG) begin
      r = d - FULL_DEG;
    end else begin
      r = d;
    end
    return 32'(r);
  endfunction

  // eight bits of long division by DIV_K, returns {remainder, quotient bits}
  function automatic logic [13:0] div_step(input logic [5:0] rem, input logic [7:0] bits);
    logic [6:0] r;
    logic [7:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int b = 7; b >= 0; b--) begin
      r = {r[5:0], bits[b]};
      if (r >= 7'(DIV_K)) begin
        r    = r - 7'(DIV_K);
        q[b] = 1'b1;
      end
    end
    return {r[5:0], q};
  endfunction

  // q30 product rounded half up
  function automatic logic signed [CW-1:0] rnd_q30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + PW'(HALF_Q);
    return CW'(s >>> Q_BITS);
  endfunction

endpackage

// ===== src/gcd_cordic.sv =====
module gcd_cordic (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         vec_mode,
  input  logic signed [gcd_pkg::CW-1:0] x_in,
  input  logic signed [gcd_pkg::CW-1:0] y_in,
  input  logic signed [gcd_pkg::CW-1:0] z_in,
  output logic signed [gcd_pkg::CW-1:0] x_out,
  output logic signed [gcd_pkg::CW-1:0] y_out,
  output logic signed [gcd_pkg::CW-1:0] z_out
);
  import gcd_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [CW-1:0] z_r [CORDIC_STEPS];

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] xp, yp, zp;
    logic                 up;

    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = z_in;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    // rotation steers on the angle left, vectoring on the sign of y
    assign up = vec_mode ? yp[CW-1] : !zp[CW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (up) begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - ATAN_TAB[i];
        end else begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + ATAN_TAB[i];
        end
      end
    end
  end

  assign x_out = x_r[CORDIC_STEPS-1];
  assign y_out = y_r[CORDIC_STEPS-1];
  assign z_out = z_r[CORDIC_STEPS-1];

endmodule

// ===== src/great_circle_distance.sv =====
// channel | ports                                   | direction
// --------+-----------------------------------------+----------
// in      | in_valid/in_ready, two points lat/lon   | input
// out     | out_valid/out_ready, out_distance_m     | output
// cfg     | cfg_wr_en, cfg_wr_data (earth radius)   | input
//
// Fully pipelined: one item per cycle unless a stall on out_ready holds it.
// Most of the depth lies in two 30-stage cordic chains and a 31-stage square root.
// Reset (synchronous, rst_n low) clears all valid bits and loads radius 6371000.
// A stall on out_ready freezes the whole pipeline; in_ready follows out_ready
// whenever the output register is full.
module great_circle_distance (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gcd_pkg::LAT_W-1:0]   in_first_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]   in_first_longitude,
  input  logic signed [gcd_pkg::LAT_W-1:0]   in_second_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]   in_second_longitude,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gcd_pkg::DIST_W-1:0]         out_distance_m,
  input  logic                               cfg_wr_en,
  input  logic [gcd_pkg::RAD_W-1:0]          cfg_wr_data
);
  import gcd_pkg::*;

  localparam int NV = 112;

  logic              adv;
  logic [NV-1:0]     vld_r;
  logic [RAD_W-1:0]  radius_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // valid bits travel with the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  // lane angles: lat diff, lon diff (halved by the radian scaling), lat1, lat2
  logic signed [34:0] raw_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_r[0] <= 35'(in_second_latitude) - 35'(in_first_latitude);
      raw_r[1] <= 35'(in_second_longitude) - 35'(in_first_longitude);
      raw_r[2] <= 35'(in_first_latitude);
      raw_r[3] <= 35'(in_second_latitude);
    end
  end

  logic signed [CW-1:0] lx [4];
  logic signed [CW-1:0] ly [4];
  logic                 lng [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam bit              IS_COS = (l >= 2);
    localparam int              SH     = IS_COS ? SH_LAT : SH_HALF;
    localparam logic [63:0]     RND    = 64'(DIV_K) << (SH - 1);

    logic signed [31:0]          wrp_r, fld_r;
    logic                        ng3_r;
    logic [30:0]                 mag_r;
    logic [62:0]                 prd_r;
    logic [DIV_NUM_W-1:0]        wq_r  [DIV_STAGES+1];
    logic [5:0]                  rem_r [DIV_STAGES+1];
    logic [1:0]                  sd_r  [DIV_STAGES+3];
    logic signed [CW-1:0]        ang_r;
    logic                        ngo_r;
    logic                        ngd_r [CORDIC_STEPS];

    // wrap, fold past the poles on the cosine lanes, magnitude, scale by pi
    always_ff @(posedge clk) begin
      if (adv) begin
        wrp_r <= wrap_deg(raw_r[l]);
        if (IS_COS && (wrp_r > QUARTER_DEG)) begin
          fld_r <= 32'(wrp_r - HALF_DEG);
          ng3_r <= 1'b1;
        end else if (IS_COS && (wrp_r < -QUARTER_DEG)) begin
          fld_r <= 32'(wrp_r + HALF_DEG);
          ng3_r <= 1'b1;
        end else begin
          fld_r <= wrp_r;
          ng3_r <= 1'b0;
        end
        mag_r    <= fld_r[31] ? 31'(-fld_r) : fld_r[30:0];
        sd_r[0]  <= {ng3_r, fld_r[31]};
        prd_r    <= 63'(mag_r) * 63'(PI_Q30);
        sd_r[1]  <= sd_r[0];
        wq_r[0]  <= DIV_NUM_W'((64'(prd_r) + RND) >> SH);
        rem_r[0] <= '0;
        sd_r[2]  <= sd_r[1];
      end
    end

    // divide by 45, eight quotient bits per stage
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [13:0] st;
      assign st = div_step(rem_r[j], wq_r[j][DIV_NUM_W-1 -: DIV_CHUNK]);
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j+1] <= st[13:8];
          wq_r[j+1]  <= {wq_r[j][DIV_NUM_W-DIV_CHUNK-1:0], st[7:0]};
          sd_r[j+3]  <= sd_r[j+2];
        end
      end
    end

    // restore the sign
    always_ff @(posedge clk) begin
      if (adv) begin
        ang_r <= sd_r[DIV_STAGES+2][0] ? -CW'(wq_r[DIV_STAGES]) : CW'(wq_r[DIV_STAGES]);
        ngo_r <= sd_r[DIV_STAGES+2][1];
      end
    end

    gcd_cordic u_rot (
      .clk      (clk),
      .en       (adv),
      .vec_mode (1'b0),
      .x_in     (GAIN_Q30),
      .y_in     ('0),
      .z_in     (ang_r),
      .x_out    (lx[l]),
      .y_out    (ly[l]),
      .z_out    ()
    );

    // fold flag alongside the cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        ngd_r[0] <= ngo_r;
        for (int k = 1; k < CORDIC_STEPS; k++) begin
          ngd_r[k] <= ngd_r[k-1];
        end
      end
    end
    assign lng[l] = ngd_r[CORDIC_STEPS-1];
  end

  // haversine term a
  logic signed [CW-1:0] cn_r [2];
  logic signed [CW-1:0] sn_r [2];
  logic signed [PW-1:0] pcc_r, ps1_r, ps2_r, p4_r;
  logic signed [CW-1:0] cc_r, t1b_r, t2_r, t1c_r, t1d_r, r4_r;
  logic signed [CW:0]   asum;
  logic [SQ_W-1:0]      a_r;
  logic [SQ_W-1:0]      sqv_r [2];

  assign asum = (CW+1)'(t1d_r) + (CW+1)'(r4_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      cn_r[0] <= lng[2] ? -lx[2] : lx[2];
      cn_r[1] <= lng[3] ? -lx[3] : lx[3];
      sn_r[0] <= ly[0];
      sn_r[1] <= ly[1];
      pcc_r   <= PW'(cn_r[0]) * PW'(cn_r[1]);
      ps1_r   <= PW'(sn_r[0]) * PW'(sn_r[0]);
      ps2_r   <= PW'(sn_r[1]) * PW'(sn_r[1]);
      cc_r    <= rnd_q30(pcc_r);
      t1b_r   <= rnd_q30(ps1_r);
      t2_r    <= rnd_q30(ps2_r);
      p4_r    <= PW'(t2_r) * PW'(cc_r);
      t1c_r   <= t1b_r;
      r4_r    <= rnd_q30(p4_r);
      t1d_r   <= t1c_r;
      // clamp a to [0, 1]
      if (asum < 0) begin
        a_r <= '0;
      end else if (asum > (CW+1)'(ONE_Q)) begin
        a_r <= SQ_W'(ONE_Q);
      end else begin
        a_r <= SQ_W'(asum);
      end
      sqv_r[0] <= a_r;
      sqv_r[1] <= SQ_W'(ONE_Q) - a_r;
    end
  end

  // rounded square roots of a and 1-a, one root bit per stage
  logic [SQ_W-1:0] sq_r [2];

  for (genvar k = 0; k < 2; k++) begin : g_sqrt
    logic [SQ_W-1:0]   rt_r [SQ_STEP];
    logic [SQ_REM-1:0] rm_r [SQ_STEP];
    logic [SQ_W-1:0]   vv_r [SQ_STEP];

    for (genvar i = 0; i < SQ_STEP; i++) begin : g_bit
      localparam int P = SQ_STEP - 1 - i;
      logic [SQ_W-1:0]   rt_p, vv_p;
      logic [SQ_REM-1:0] rm_p;
      logic [61:0]       nn;
      logic [34:0]       remsh, trial;

      if (i == 0) begin : g_first
        assign rt_p = '0;
        assign rm_p = '0;
        assign vv_p = sqv_r[k];
      end else begin : g_next
        assign rt_p = rt_r[i-1];
        assign rm_p = rm_r[i-1];
        assign vv_p = vv_r[i-1];
      end

      assign nn    = {1'b0, vv_p, 30'b0};
      assign remsh = {rm_p, nn[2*P+1 -: 2]};
      assign trial = {2'b00, rt_p, 2'b01};

      always_ff @(posedge clk) begin
        if (adv) begin
          vv_r[i] <= vv_p;
          if (remsh >= trial) begin
            rm_r[i] <= SQ_REM'(remsh - trial);
            rt_r[i] <= {rt_p[SQ_W-2:0], 1'b1};
          end else begin
            rm_r[i] <= SQ_REM'(remsh);
            rt_r[i] <= {rt_p[SQ_W-2:0], 1'b0};
          end
        end
      end
    end

    // round to nearest
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k] <= rt_r[SQ_STEP-1] +
                   SQ_W'(rm_r[SQ_STEP-1] > SQ_REM'(rt_r[SQ_STEP-1]));
      end
    end
  end

  // central half-angle by vectoring
  logic signed [CW-1:0] zv;

  gcd_cordic u_vec (
    .clk      (clk),
    .en       (adv),
    .vec_mode (1'b1),
    .x_in     (CW'(sq_r[1])),
    .y_in     (CW'(sq_r[0])),
    .z_in     ('0),
    .x_out    (),
    .y_out    (),
    .z_out    (zv)
  );

  // scale by radius, round and saturate
  logic [32:0] z2;
  logic [56:0] prod_r;
  logic [57:0] dsum;
  logic [27:0] dsh;

  assign z2   = zv[CW-1] ? '0 : {zv[31:0], 1'b0};
  assign dsum = 58'(prod_r) + 58'(HALF_Q);
  assign dsh  = dsum[57:30];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= 57'(radius_r) * 57'(z2);
      if (dsh > 28'(DIST_MAX)) begin
        out_dist_r <= DIST_MAX;
      end else begin
        out_dist_r <= DIST_W'(dsh);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NV-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance_m = out_dist_r;

endmodule

// ===== tb/tb_great_circle_distance.sv =====
module tb_great_circle_distance;
  import gcd_pkg::*;

  // one input item: two points
  typedef struct packed {
    logic signed [LAT_W-1:0] lat1;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon2;
  } point_pair_t;

  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 2000000;

  // random item kinds
  localparam int PAIR_NEAR = 0;
  localparam int PAIR_RAW  = 1;

  localparam longint ATAN_Q [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h100000, 64'h80000, 64'h40000, 64'h20000, 64'h10000,
    64'h8000, 64'h4000, 64'h2000, 64'h1000, 64'h800,
    64'h400, 64'h200, 64'h100, 64'h80, 64'h40,
    64'h20, 64'h10, 64'h8, 64'h4, 64'h2
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [LAT_W-1:0] in_first_latitude;
  logic signed [LON_W-1:0] in_first_longitude;
  logic signed [LAT_W-1:0] in_second_latitude;
  logic signed [LON_W-1:0] in_second_longitude;
  logic out_valid;
  logic out_ready;
  logic [DIST_W-1:0] out_distance_m;
  logic cfg_wr_en;
  logic [RAD_W-1:0] cfg_wr_data;

  great_circle_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_latitude(in_first_latitude), .in_first_longitude(in_first_longitude),
    .in_second_latitude(in_second_latitude), .in_second_longitude(in_second_longitude),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance_m(out_distance_m),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // radius as the predictor sees it
  logic [RAD_W-1:0] radius_m;
  point_pair_t pending_pairs[$];
  logic [DIST_W-1:0] expected_dist[$];
  logic in_ready_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int errors;
  int checked;
  longint cycle_count;

  // floor shift, valid for negatives
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_round(longint a, longint b);
    return (a * b + HALF_Q) >>> 30;
  endfunction

  function automatic longint wrap_angle(longint d);
    longint r;
    r = d % FULL_L;
    if (r < 0) r += FULL_L;
    if (r >= HALF_L) r -= FULL_L;
    return r;
  endfunction

  function automatic longint deg_to_q30(longint x, longint denom);
    longint unsigned u;
    longint unsigned q;
    u = (x < 0) ? -x : x;
    q = (u * 64'd3373259426 + longint'(denom) / 2) / denom;
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  // rotation mode: returns {sin, cos} via output arguments
  function automatic void rotate(input longint z, output longint s, output longint c);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint half_sine(longint d);
    longint s;
    longint c;
    rotate(deg_to_q30(wrap_angle(d), FULL_L), s, c);
    return s;
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint r;
    longint s;
    longint c;
    bit neg;
    r = wrap_angle(lat);
    neg = 0;
    if (r > QUARTER_L) begin
      r -= HALF_L; neg = 1;
    end else if (r < -QUARTER_L) begin
      r += HALF_L; neg = 1;
    end
    rotate(deg_to_q30(r, HALF_L), s, c);
    return neg ? -c : c;
  endfunction

  function automatic longint unsigned root_round(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q[i];
      end
    end
    return z;
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(point_pair_t p, logic [RAD_W-1:0] r);
    longint s1;
    longint s2;
    longint cc;
    longint a;
    longint sa;
    longint sb;
    longint z;
    longint unsigned dist_val;
    s1 = half_sine(longint'(p.lat2) - longint'(p.lat1));
    s2 = half_sine(longint'(p.lon2) - longint'(p.lon1));
    cc = mul_round(lat_cosine(longint'(p.lat1)), lat_cosine(longint'(p.lat2)));
    a = mul_round(s1, s1) + mul_round(mul_round(s2, s2), cc);
    if (a < 0) a = 0;
    if (a > ONE_Q) a = ONE_Q;
    sa = root_round(longint'(a) << 30);
    sb = root_round(longint'(ONE_Q - a) << 30);
    z = vector_angle(sa, sb);
    if (z < 0) z = 0;
    dist_val = (longint'(r) * (2 * z) + HALF_Q) >> 30;
    if (dist_val > 64'd67108863) dist_val = 67108863;
    return DIST_W'(dist_val);
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver: next item presented at falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_pair_t p;
        p = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_first_latitude <= p.lat1;
        in_first_longitude <= p.lon1;
        in_second_latitude <= p.lat2;
        in_second_longitude <= p.lon2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accept sampled at rising edge
  always @(posedge clk) begin
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      point_pair_t p;
      p = '{in_first_latitude, in_first_longitude, in_second_latitude, in_second_longitude};
      expected_dist.push_back(predict_distance(p, radius_m));
    end
  end

  // receiver stall, with a long hold-off counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_dist.size() == 0) begin
        $error("distance_m: no item expected, actual %0d", out_distance_m);
        errors++;
      end else begin
        logic [DIST_W-1:0] e;
        e = expected_dist.pop_front();
        checked++;
        if (e !== out_distance_m) begin
          $error("distance_m: expected %0d actual %0d", e, out_distance_m);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL great_circle_distance");
      $finish;
    end
  end

  function automatic longint rand_range(longint lo, longint hi);
    longint unsigned span;
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  function automatic point_pair_t rand_pair(int mode);
    point_pair_t p;
    longint lmax;
    longint gmax;
    lmax = 754974720;
    gmax = 1509949440;
    case (mode)
      PAIR_NEAR: begin
        // nearby points
        p.lat1 = LAT_W'(rand_range(-lmax, lmax));
        p.lon1 = LON_W'(rand_range(-gmax, gmax));
        p.lat2 = LAT_W'(longint'(p.lat1) + rand_range(-100000, 100000));
        p.lon2 = LON_W'(longint'(p.lon1) + rand_range(-100000, 100000));
      end
      PAIR_RAW: begin
        // full field, raw bits
        p.lat1 = LAT_W'($urandom); p.lon1 = LON_W'($urandom);
        p.lat2 = LAT_W'($urandom); p.lon2 = LON_W'($urandom);
      end
      default: begin
        p.lat1 = LAT_W'(rand_range(-lmax, lmax));
        p.lon1 = LON_W'(rand_range(-gmax, gmax));
        p.lat2 = LAT_W'(rand_range(-lmax, lmax));
        p.lon2 = LON_W'(rand_range(-gmax, gmax));
      end
    endcase
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid || expected_dist.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radius(logic [RAD_W-1:0] r);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    radius_m = r;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair($urandom_range(2)));
  endtask

  localparam int PHASES = 4;
  int idle_tab [PHASES] = '{0, 58, 0, 7};
  int stall_tab [PHASES] = '{0, 0, 58, 7};
  logic [RAD_W-1:0] radius_tab [5] = '{24'd6371000, 24'hFFFFFF, 24'd1, 24'd1737400, 24'd0};

  initial begin
    rst_n = 0;
    in_valid = 0;
    out_ready = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_first_latitude = '0;
    in_first_longitude = '0;
    in_second_latitude = '0;
    in_second_longitude = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    errors = 0;
    checked = 0;
    cycle_count = 0;
    radius_m = RADIUS_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, poles, antipodes, wraparound, raw field limits
    pending_pairs.push_back('{0, 0, 0, 0});
    pending_pairs.push_back('{754974720, 0, -754974720, 0});
    pending_pairs.push_back('{0, 0, 0, 1509949440});
    pending_pairs.push_back('{0, -1509949440, 0, 1509949440});
    pending_pairs.push_back('{0, 0, 0, 1509949440 / 2});
    pending_pairs.push_back('{754974720, 123, 754974720, -999999});
    pending_pairs.push_back('{-754974720, 0, 754974720, 1509949440});
    pending_pairs.push_back('{31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000});
    pending_pairs.push_back('{31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF});
    pending_pairs.push_back('{31'sh7FFFFFFF, 32'shFFFFFFFF, 0, 0});
    pending_pairs.push_back('{0, 0, 0, 1});
    pending_pairs.push_back('{1, 0, 0, 0});
    pending_pairs.push_back('{377487360, 0, -377487360, 1509949440});
    pending_pairs.push_back('{900000000, 0, 900000000, 0});
    pending_pairs.push_back('{-900000000, 1, 600000000, -2000000000});
    wait_drained();

    // every radius, each through all idle/stall phases
    for (int k = 0; k < 5; k++) begin
      set_radius(radius_tab[k]);
      pending_pairs.push_back('{0, 0, 0, 1509949440});
      pending_pairs.push_back('{754974720, 0, -754974720, 0});
      for (int ph = 0; ph < PHASES; ph++) begin
        send_idle_pct = idle_tab[ph];
        recv_stall_pct = stall_tab[ph];
        queue_random((k == 0) ? 200 : 55);
        if (ph == 0) hold_off_cycles = 400;
        wait_drained();
      end
    end
    set_radius(RADIUS_RESET);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    queue_random(250);
    wait_drained();

    $display("covered %0d distances over 6 radius settings incl. 0, 1 and max", checked);
    $display("idle/stall phases, long receiver hold-off and full drains exercised");
    if (errors == 0) begin
      $display("PASS great_circle_distance");
    end else begin
      $display("FAIL great_circle_distance");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gcd_pkg.sv
src/gcd_cordic.sv
src/great_circle_distance.sv
tb/tb_great_circle_distance.sv
